@@ rtl/mtet_pkg.sv @@
package mtet_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned CPT_W    = 16;
    localparam int unsigned TURN_W   = 16;
    localparam int unsigned HIST_W   = 18;
    localparam int unsigned AXIS_W   = 33;

    localparam logic [CPT_W:0] GLITCH_MARGIN = (CPT_W + 1)'(500);
    localparam logic [CPT_W-1:0] CPT_RESET   = CPT_W'(8192);

    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W - 1){1'b0}}};
    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W - 1){1'b1}}};

    typedef logic [SAMPLE_W-1:0]       t_sample;
    typedef logic [CPT_W-1:0]          t_cpt;
    typedef logic signed [TURN_W-1:0]  t_turn;
    typedef logic signed [HIST_W-1:0]  t_hist;
    typedef logic signed [AXIS_W-1:0]  t_axis;

endpackage

@@ rtl/multi_turn_encoder_tracker_unit.sv @@
// channel  | direction | handshake                   | payload
// in       | to block  | i_in_valid / o_in_stall     | i_sample, i_zero_request
// out      | from block| o_out_valid / i_out_stall   | o_axis_count
// cfg      | to block  | i_cfg_valid / o_cfg_ready   | i_cfg_data (counts per turn)
//
// one sample per cycle sustained unless a stalled result backs the pipeline up
// tracking state (turn count, zero, sample history) updates when stage one advances
// the multiply by counts per turn sits in its own stage before the result register
// synchronous active-low reset clears the tracker and sets counts per turn to 8192
// a stalled result holds; the pipeline keeps filling until all three stages are full
module multi_turn_encoder_tracker_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  mtet_pkg::t_sample       i_sample,
    input  logic                    i_zero_request,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output mtet_pkg::t_axis         o_axis_count,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  mtet_pkg::t_cpt          i_cfg_data
);
    import mtet_pkg::*;

    t_cpt    r_cpt;

    logic    r_s1_valid;
    t_sample r_s1_sample;
    logic    r_s1_zreq;

    logic    r_started;
    t_turn   r_turn;
    t_sample r_zero;
    t_hist   r_last;
    t_hist   r_older;

    logic    r_s2_valid;
    t_turn   r_s2_turn;
    t_hist   r_s2_cur;
    t_sample r_s2_zero;

    logic    r_out_valid;
    t_axis   r_axis;

    logic adv_out;
    logic adv2;
    logic adv1;

    logic    init;
    t_hist   eff_last;
    t_hist   eff_older;
    t_turn   eff_turn;
    t_sample eff_zero;
    t_hist   cur0;

    logic signed [HIST_W:0]   diff1;
    logic        [HIST_W:0]   abs1;
    logic        [CPT_W:0]    glitch_lim;
    logic                     glitch;
    logic signed [HIST_W+1:0] ext;
    t_hist                    ext_sat;
    t_hist                    n_cur;
    logic signed [HIST_W:0]   diff2;
    logic signed [23:0]       d24;
    logic signed [23:0]       ten;
    logic        [CPT_W+3:0]  nine;
    logic signed [23:0]       nine24;
    logic                     fwd;
    logic                     bwd;
    t_turn                    n_turn;

    logic signed [CPT_W:0]    cpt_s;
    logic signed [32:0]       prod;
    logic signed [34:0]       sum;

    assign o_cfg_ready = 1'b1;

    assign adv_out    = !r_out_valid || !i_out_stall;
    assign adv2       = !r_s2_valid || adv_out;
    assign adv1       = !r_s1_valid || adv2;
    assign o_in_stall = !adv1;

    // tracking update for the item in stage one
    always_comb begin
        init      = r_s1_zreq || !r_started;
        cur0      = HIST_W'({2'b00, r_s1_sample});
        eff_last  = init ? cur0 : r_last;
        eff_older = init ? cur0 : r_older;
        eff_turn  = init ? '0 : r_turn;
        eff_zero  = init ? r_s1_sample : r_zero;

        diff1      = (HIST_W + 1)'(cur0) - (HIST_W + 1)'(eff_last);
        abs1       = diff1[HIST_W] ? (HIST_W + 1)'(-diff1) : (HIST_W + 1)'(diff1);
        glitch_lim = {1'b0, r_cpt} + GLITCH_MARGIN;
        glitch     = abs1 > (HIST_W + 1)'(glitch_lim);

        // extrapolate and clamp to the history range
        ext = ((HIST_W + 2)'(eff_last) <<< 1) - (HIST_W + 2)'(eff_older);
        if (ext[HIST_W+1:HIST_W-1] == 3'b000 || ext[HIST_W+1:HIST_W-1] == 3'b111) begin
            ext_sat = ext[HIST_W-1:0];
        end else if (ext[HIST_W+1]) begin
            ext_sat = {1'b1, {(HIST_W - 1){1'b0}}};
        end else begin
            ext_sat = {1'b0, {(HIST_W - 1){1'b1}}};
        end
        n_cur = glitch ? ext_sat : cur0;

        // wrap test: 10 * diff against 9 * counts per turn
        diff2  = (HIST_W + 1)'(n_cur) - (HIST_W + 1)'(eff_last);
        d24    = 24'(diff2);
        ten    = (d24 <<< 3) + (d24 <<< 1);
        nine   = {r_cpt, 3'b000} + (CPT_W + 4)'(r_cpt);
        nine24 = $signed(24'(nine));
        fwd    = ten > nine24;
        bwd    = (-ten) > nine24;

        n_turn = eff_turn;
        if (fwd) begin
            if (eff_turn != TURN_MIN) begin
                n_turn = eff_turn - TURN_W'(1);
            end
        end else if (bwd) begin
            if (eff_turn != TURN_MAX) begin
                n_turn = eff_turn + TURN_W'(1);
            end
        end
    end

    always_comb begin
        cpt_s = $signed({1'b0, r_cpt});
        prod  = r_s2_turn * cpt_s;
        sum   = 35'(prod) + 35'(r_s2_cur) - 35'($signed({1'b0, r_s2_zero}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpt       <= CPT_RESET;
            r_s1_valid  <= 1'b0;
            r_started   <= 1'b0;
            r_turn      <= '0;
            r_zero      <= '0;
            r_last      <= '0;
            r_older     <= '0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cpt <= i_cfg_data;
            end
            if (adv1) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv2) begin
                r_s2_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_started <= 1'b1;
                    r_turn    <= n_turn;
                    r_zero    <= eff_zero;
                    r_last    <= n_cur;
                    r_older   <= eff_last;
                end
            end
            if (adv_out) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_in_valid) begin
            r_s1_sample <= i_sample;
            r_s1_zreq   <= i_zero_request;
        end
        if (adv2 && r_s1_valid) begin
            r_s2_turn <= n_turn;
            r_s2_cur  <= n_cur;
            r_s2_zero <= eff_zero;
        end
        if (adv_out && r_s2_valid) begin
            r_axis <= sum[AXIS_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_axis_count = r_axis;

endmodule

@@ rtl/mtet_checker.sv @@
module mtet_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    i_zero_request,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input mtet_pkg::t_axis         o_axis_count,
    input logic                    i_cfg_valid,
    input logic                    o_cfg_ready
);
    import mtet_pkg::*;

    // a zero request always reports position zero
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_zero_request) ##1 !i_out_stall ##1 !i_out_stall
        |=> (o_out_valid && o_axis_count == '0))
        else $error("zero request did not give a zero result");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_axis_count)))
        else $error("stalled result transfer changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write not taken");

endmodule

bind multi_turn_encoder_tracker_unit mtet_checker u_mtet_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_zero_request (i_zero_request),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_axis_count   (o_axis_count),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready)
);

@@ tb/tb_multi_turn_encoder_tracker_unit.sv @@
module tb_multi_turn_encoder_tracker_unit;

    import mtet_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam longint HIST_LO = -(longint'(1) << (HIST_W - 1));
    localparam longint HIST_HI = (longint'(1) << (HIST_W - 1)) - 1;

    typedef struct {
        logic    is_cfg;
        t_cpt    cpt;
        t_sample sample;
        logic    zero_req;
    } t_enc_item;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    o_in_stall;
    t_sample i_sample = '0;
    logic    i_zero_request = 1'b0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_axis   o_axis_count;
    logic    i_cfg_valid = 1'b0;
    logic    o_cfg_ready;
    t_cpt    i_cfg_data = '0;

    multi_turn_encoder_tracker_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_zero_request (i_zero_request),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_axis_count   (o_axis_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_enc_item encoder_reads[$];
    t_axis     expected_axis_counts[$];
    int        mismatches = 0;

    // tracker copy
    bit     trk_started = 1'b0;
    longint trk_turns = 0;
    longint trk_zero = 0;
    longint trk_last = 0;
    longint trk_older = 0;
    longint trk_cpt = longint'(CPT_RESET);

    function automatic t_axis track_axis(input t_sample smp, input logic zreq);
        longint cur;
        longint diff;
        longint ext;
        longint pos;
        cur = longint'(smp);
        if (zreq || !trk_started) begin
            trk_started = 1'b1;
            trk_last = cur;
            trk_older = cur;
            trk_turns = 0;
            trk_zero = cur;
        end
        diff = cur - trk_last;
        if ((diff < 0 ? -diff : diff) > trk_cpt + longint'(GLITCH_MARGIN)) begin
            ext = 2 * trk_last - trk_older;
            if (ext < HIST_LO) ext = HIST_LO;
            if (ext > HIST_HI) ext = HIST_HI;
            cur = ext;
        end
        diff = cur - trk_last;
        if (10 * diff > 9 * trk_cpt) begin
            if (trk_turns > longint'(TURN_MIN)) trk_turns--;
        end else if (-10 * diff > 9 * trk_cpt) begin
            if (trk_turns < longint'(TURN_MAX)) trk_turns++;
        end
        pos = trk_turns * trk_cpt + cur - trk_zero;
        trk_older = trk_last;
        trk_last = cur;
        return t_axis'(pos);
    endfunction

    task automatic push_sample(input int smp, input bit zreq);
        t_enc_item it;
        it.is_cfg = 1'b0;
        it.cpt = '0;
        it.sample = t_sample'(smp);
        it.zero_req = zreq;
        encoder_reads.push_back(it);
    endtask

    task automatic push_cpt(input int cpt);
        t_enc_item it;
        it.is_cfg = 1'b1;
        it.cpt = t_cpt'(cpt);
        it.sample = '0;
        it.zero_req = 1'b0;
        encoder_reads.push_back(it);
    endtask

    // rotor spinning at changing speeds, with glitches, zeroing and out-of-range reads
    task automatic add_spin_phase(input int cpt, input int count);
        longint ang;
        longint vel;
        longint modulus;
        int span;
        int smp;
        int r;
        push_cpt(cpt);
        modulus = (cpt >= 2) ? cpt : 65536;
        span = (cpt >= 2) ? cpt : 1000;
        ang = $urandom_range(0, 65535);
        vel = 0;
        for (int k = 0; k < count; k++) begin
            if (k == 0 || $urandom_range(0, 39) == 0) begin
                case ($urandom_range(0, 3))
                    0: vel = $urandom_range(0, span / 50 + 1);
                    1: vel = $urandom_range(0, span / 2);
                    2: vel = span - $urandom_range(1, span / 10 + 1);
                    default: vel = 0;
                endcase
                if ($urandom_range(0, 1)) vel = -vel;
            end
            ang += vel;
            smp = int'(((ang % modulus) + modulus) % modulus);
            r = $urandom_range(0, 99);
            if (r < 4) begin
                push_sample($urandom_range(0, 65535), 1'b0);
            end else if (r < 6) begin
                push_sample(smp, 1'b1);
            end else if (r < 9 && cpt < 65535) begin
                push_sample($urandom_range(cpt, 65535), 1'b0);
            end else begin
                push_sample(smp, 1'b0);
            end
        end
    endtask

    // one-count steps pile up turns in one direction
    task automatic add_turn_pileup(input bit downward, input int laps);
        int base;
        int span;
        span = 100;
        base = downward ? 0 : span;
        push_cpt(1);
        push_sample(base, 1'b1);
        repeat (laps) begin
            for (int k = 1; k <= span; k++) push_sample(downward ? k : span - k, 1'b0);
            push_sample(base, 1'b0);
        end
        push_cpt(65535);
        push_sample(base, 1'b0);
        push_sample(base + 300, 1'b0);
        push_sample(base, 1'b0);
    endtask

    // sender
    t_enc_item next_item;
    int        burst_left = 0;
    int        gap_left = 0;
    int        quiet_cycles = 0;
    logic      in_hold;
    logic      cfg_hold;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_axis_counts.push_back(track_axis(i_sample, i_zero_request));
            end
            if (i_cfg_valid && o_cfg_ready) trk_cpt = longint'(i_cfg_data);
            in_hold = i_in_valid && o_in_stall;
            cfg_hold = i_cfg_valid && !o_cfg_ready;
            if (expected_axis_counts.size() == 0 && !in_hold) quiet_cycles++;
            else quiet_cycles = 0;

            if (in_hold || cfg_hold) begin
                // transfer pending, payload holds
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
                i_cfg_valid <= 1'b0;
                i_sample <= t_sample'($urandom);
                i_zero_request <= 1'($urandom_range(0, 1));
            end else if (encoder_reads.size() > 0 && encoder_reads[0].is_cfg) begin
                i_in_valid <= 1'b0;
                i_sample <= t_sample'($urandom);
                if (quiet_cycles >= SETTLE_CYCLES) begin
                    next_item = encoder_reads.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_data <= next_item.cpt;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end else if (encoder_reads.size() > 0) begin
                next_item = encoder_reads.pop_front();
                i_in_valid <= 1'b1;
                i_sample <= next_item.sample;
                i_zero_request <= next_item.zero_req;
                i_cfg_valid <= 1'b0;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(0, 7) == 0) begin
                    burst_left = $urandom_range(200, 600);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
                                                           : $urandom_range(0, 5);
                end
            end else begin
                i_in_valid <= 1'b0;
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // receiver
    t_axis want_axis;
    int    stall_mode = 0;
    int    stall_left = 0;
    int    stall_phase = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_axis_counts.size() == 0) begin
                    mismatches++;
                    $display("%0t axis_count: expected none, actual %0d",
                             $time, o_axis_count);
                end else begin
                    want_axis = expected_axis_counts.pop_front();
                    if (o_axis_count !== want_axis) begin
                        mismatches++;
                        $display("%0t axis_count: expected %0d, actual %0d",
                                 $time, want_axis, o_axis_count);
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(50, 500);
            end else begin
                stall_left--;
            end
            stall_phase++;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 9) < 7);
                default: i_out_stall <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        // directed, at the reset value of counts per turn
        push_sample(100, 1'b0);
        push_sample(8100, 1'b0);
        push_sample(50, 1'b0);
        push_sample(65535, 1'b0);
        push_sample(0, 1'b1);
        push_sample(65535, 1'b1);
        push_sample(65535, 1'b0);
        push_sample(0, 1'b0);
        // wrap threshold edges
        push_sample(0, 1'b1);
        push_sample(7372, 1'b0);
        push_sample(0, 1'b0);
        push_sample(7373, 1'b0);
        push_sample(0, 1'b0);
        // glitch threshold edges
        push_sample(0, 1'b1);
        push_sample(8692, 1'b0);
        push_sample(0, 1'b0);
        push_sample(8693, 1'b0);
        push_sample(43690, 1'b1);
        push_sample(21845, 1'b0);

        // extrapolation running into both history limits
        push_cpt(8192);
        push_sample(0, 1'b1);
        for (int s = 8600; s < 65536; s += 8600) push_sample(s, 1'b0);
        repeat (12) push_sample(0, 1'b0);
        push_sample(65535, 1'b1);
        for (int s = 65535 - 8600; s >= 0; s -= 8600) push_sample(s, 1'b0);
        repeat (18) push_sample(65535, 1'b0);

        add_spin_phase(65535, 100);
        add_spin_phase(2, 100);
        add_spin_phase(0, 100);
        add_spin_phase(1, 100);
        add_spin_phase(360, 100);
        add_spin_phase(1000, 100);
        add_spin_phase(4096, 100);
        add_spin_phase(8192, 100);
        add_spin_phase($urandom_range(2, 65535), 100);
        add_spin_phase($urandom_range(2, 65535), 100);
        add_spin_phase($urandom_range(2, 200), 100);

        add_turn_pileup(1'b1, 3);
        add_turn_pileup(1'b0, 3);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (encoder_reads.size() != 0 || i_in_valid || i_cfg_valid
               || expected_axis_counts.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
